FILE: hdl/steady_state_replacement_top_macros.svh
// -----------------------------------------------------------------------------
// Assertion macros for the steady-state replacement block
// Each macro expects clk and rst to be visible where it is used.
// -----------------------------------------------------------------------------
`ifndef STEADY_STATE_REPLACEMENT_TOP_MACROS_SVH
`define STEADY_STATE_REPLACEMENT_TOP_MACROS_SVH

// same-cycle implication
`define SSR_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ssr assertion failed");

// next-cycle implication
`define SSR_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ssr assertion failed");

`endif

FILE: hdl/ssr_pkg.sv
// -----------------------------------------------------------------------------
// ssr_pkg
// Shared constants and types of the steady-state replacement block.
// -----------------------------------------------------------------------------
package ssr_pkg;

  localparam int MAX_ENTRIES  = 32;
  localparam int FITNESS_BITS = 16;

  localparam int IDX_W  = $clog2(MAX_ENTRIES);
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int SLOT_W = 5;
  localparam int ACT_W  = 6;
  localparam int CMD_W  = 2;
  localparam int FIT_W  = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_POP = 2'd0,
    CMD_LOAD_OFF = 2'd1,
    CMD_RUN      = 2'd2
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  // running search result handed from cell to cell
  typedef struct packed {
    logic [FITNESS_BITS-1:0] min_fit;
    logic [IDX_W-1:0]        min_idx;
    logic [FITNESS_BITS-1:0] max_fit;
    logic [IDX_W-1:0]        max_idx;
  } scan_t;

  // store writes broadcast to every cell
  typedef struct packed {
    logic                    pop_en;
    logic [IDX_W-1:0]        pop_slot;
    logic [FITNESS_BITS-1:0] pop_data;
    logic                    off_en;
    logic [IDX_W-1:0]        off_slot;
    logic [FITNESS_BITS-1:0] off_data;
  } cell_wr_t;

endpackage

FILE: hdl/ssr_channels.sv
// -----------------------------------------------------------------------------
// ssr channels
// Valid/ready channels of the steady-state replacement block.
// -----------------------------------------------------------------------------
interface ssr_req_if;
  import ssr_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [SLOT_W-1:0] slot;
  logic [FIT_W-1:0]  fitness_in;
  modport source (output valid, command, slot, fitness_in, input ready);
  modport sink (input valid, command, slot, fitness_in, output ready);
endinterface

interface ssr_res_if;
  import ssr_pkg::*;
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] population_slot;
  logic [SLOT_W-1:0] offspring_slot;
  logic              replaced;
  logic [FIT_W-1:0]  moved_fitness;
  logic              last;
  modport source (output valid, population_slot, offspring_slot, replaced, moved_fitness,
                  last, input ready);
  modport sink (input valid, population_slot, offspring_slot, replaced, moved_fitness,
                last, output ready);
endinterface

interface ssr_cfg_if;
  import ssr_pkg::*;
  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] active_count;
  modport source (output valid, active_count, input ready);
  modport sink (input valid, active_count, output ready);
endinterface

FILE: hdl/ssr_cell.sv
// -----------------------------------------------------------------------------
// ssr_cell
// One entry of both stores plus one stage of the min/max search chain.
// -----------------------------------------------------------------------------
module ssr_cell (
  input  logic                    clk,
  input  logic [ssr_pkg::IDX_W-1:0] index,
  input  logic [ssr_pkg::CNT_W-1:0] count,
  input  ssr_pkg::cell_wr_t       wr,
  input  ssr_pkg::scan_t          scan_in,
  output ssr_pkg::scan_t          scan_out
);
  import ssr_pkg::*;

  logic [FITNESS_BITS-1:0] pop;
  logic [FITNESS_BITS-1:0] off;
  scan_t                   scan_next;

  always_comb begin
    scan_next = scan_in;
    if (index == '0) begin
      // head of the chain seeds the search
      scan_next.min_fit = pop;
      scan_next.min_idx = '0;
      scan_next.max_fit = off;
      scan_next.max_idx = '0;
    end else if (CNT_W'(index) < count) begin
      // strict compares keep the first index on ties
      if (pop < scan_in.min_fit) begin
        scan_next.min_fit = pop;
        scan_next.min_idx = index;
      end
      if (off > scan_in.max_fit) begin
        scan_next.max_fit = off;
        scan_next.max_idx = index;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_out <= scan_next;
    if (wr.pop_en && wr.pop_slot == index) begin
      pop <= wr.pop_data;
    end
    if (wr.off_en && wr.off_slot == index) begin
      off <= wr.off_data;
    end
  end

endmodule

FILE: hdl/ssr_ctrl.sv
// -----------------------------------------------------------------------------
// ssr_ctrl
// Request decode, round sequencing, store write-back and result register.
// -----------------------------------------------------------------------------
module ssr_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  ssr_req_if.sink                   request,
  ssr_res_if.source                 result,
  ssr_cfg_if.sink                   cfg,
  input  ssr_pkg::scan_t            tail,
  output ssr_pkg::cell_wr_t         wr,
  output logic [ssr_pkg::CNT_W-1:0] count
);
  import ssr_pkg::*;

  state_t           state, state_next;
  logic [ACT_W-1:0] active_count;
  logic [CNT_W-1:0] scan_cnt, scan_cnt_next;
  logic [CNT_W-1:0] round, round_next;
  logic             out_free;
  logic             round_end;
  logic             rep;
  logic             is_last;

  assign cfg.ready = 1'b1;

  always_comb begin
    if (32'(active_count) > MAX_ENTRIES) begin
      count = CNT_W'(MAX_ENTRIES);
    end else begin
      count = CNT_W'(active_count);
    end
  end

  assign out_free  = !result.valid || result.ready;
  // tail is settled once the chain has run its full length since the last write
  assign round_end = (state == ST_SCAN) && (scan_cnt == CNT_W'(MAX_ENTRIES)) && out_free;
  assign rep       = tail.max_fit > tail.min_fit;
  assign is_last   = (round == count - 1'b1);

  assign request.ready = (state == ST_IDLE);

  always_comb begin
    state_next    = state;
    scan_cnt_next = scan_cnt;
    round_next    = round;
    wr            = '0;
    case (state)
      ST_IDLE: begin
        if (request.valid) begin
          if (request.command == CMD_LOAD_POP || request.command == CMD_LOAD_OFF) begin
            if (CNT_W'(request.slot) < count) begin
              wr.pop_en   = (request.command == CMD_LOAD_POP);
              wr.off_en   = (request.command == CMD_LOAD_OFF);
              wr.pop_slot = IDX_W'(request.slot);
              wr.off_slot = IDX_W'(request.slot);
              wr.pop_data = FITNESS_BITS'(request.fitness_in);
              wr.off_data = FITNESS_BITS'(request.fitness_in);
            end
          end else if (request.command == CMD_RUN && count != '0) begin
            state_next    = ST_SCAN;
            scan_cnt_next = '0;
            round_next    = '0;
          end
        end
      end
      ST_SCAN: begin
        if (scan_cnt != CNT_W'(MAX_ENTRIES)) begin
          scan_cnt_next = scan_cnt + 1'b1;
        end
        if (round_end) begin
          wr.pop_en     = rep;
          wr.pop_slot   = tail.min_idx;
          wr.pop_data   = tail.max_fit;
          wr.off_en     = 1'b1;
          wr.off_slot   = tail.max_idx;
          wr.off_data   = '0;
          scan_cnt_next = '0;
          round_next    = round + 1'b1;
          if (is_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      active_count <= ACT_W'(32);
      scan_cnt     <= '0;
      round        <= '0;
      result.valid <= 1'b0;
    end else begin
      state    <= state_next;
      scan_cnt <= scan_cnt_next;
      round    <= round_next;
      if (cfg.valid) begin
        active_count <= cfg.active_count;
      end
      if (round_end) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (round_end) begin
      result.population_slot <= SLOT_W'(tail.min_idx);
      result.offspring_slot  <= SLOT_W'(tail.max_idx);
      result.replaced        <= rep;
      result.moved_fitness   <= FIT_W'(tail.max_fit);
      result.last            <= is_last;
    end
  end

endmodule

FILE: hdl/steady_state_replacement_top.sv
// -----------------------------------------------------------------------------
// steady_state_replacement_top
// Steady-state replacement for one population group.
// Channels: request (command, slot, fitness_in), result (one item per round),
// cfg (active_count write, always ready).
// A load request writes one fitness entry when its slot is below the count
// and gives no result. A run request gives active_count results, at most
// MAX_ENTRIES. Each round walks the search through the chain of MAX_ENTRIES
// cells, one cell per cycle. The search chain length sets the round length;
// rounds follow one another since each round reads what the previous one
// wrote back.
// request.ready is high only while no run is in progress. The result register
// lets the next round search while a result waits; if the receiver stalls,
// the block holds at the end of the following round until the register frees.
// Reset returns to idle, drops result.valid and sets active_count to 32; the
// fitness stores are not cleared and must be loaded before a run reads them.
// -----------------------------------------------------------------------------
module steady_state_replacement_top (
  input logic       clk,
  input logic       rst,
  ssr_req_if.sink   request,
  ssr_res_if.source result,
  ssr_cfg_if.sink   cfg
);
  import ssr_pkg::*;

  scan_t            chain [MAX_ENTRIES];
  cell_wr_t         wr;
  logic [CNT_W-1:0] count;

  ssr_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .result  (result),
    .cfg     (cfg),
    .tail    (chain[MAX_ENTRIES-1]),
    .wr      (wr),
    .count   (count)
  );

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    ssr_cell u_cell (
      .clk      (clk),
      .index    (IDX_W'(i)),
      .count    (count),
      .wr       (wr),
      .scan_in  ((i == 0) ? '0 : chain[(i == 0) ? 0 : i-1]),
      .scan_out (chain[i])
    );
  end

endmodule

FILE: hdl/ssr_checker.sv
// -----------------------------------------------------------------------------
// ssr_checker
// Port-level checks of the steady-state replacement block.
// -----------------------------------------------------------------------------
`include "steady_state_replacement_top_macros.svh"

module ssr_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_ready,
  input logic                        res_valid,
  input logic                        res_ready,
  input logic                        res_replaced,
  input logic                        res_last,
  input logic [ssr_pkg::FIT_W-1:0]   res_moved_fitness,
  input logic [ssr_pkg::SLOT_W-1:0]  res_population_slot
);
  import ssr_pkg::*;

  // stalled result holds
  `SSR_ASSERT_NEXT(a_res_hold, res_valid && !res_ready,
                   res_valid && $stable(res_moved_fitness) && $stable(res_population_slot))
  // a replacement needs a fitness above the worst, so never zero
  `SSR_ASSERT_IMPL(a_rep_nonzero, res_valid && res_replaced, res_moved_fitness != '0)
  // a pending non-final result means the run is still going
  `SSR_ASSERT_IMPL(a_run_busy, res_valid && !res_last, !req_ready)
  // a fresh result only comes out of a run
  `SSR_ASSERT_IMPL(a_res_from_run, $rose(res_valid), !$past(req_ready))

endmodule

bind steady_state_replacement_top ssr_checker u_ssr_checker (
  .clk                 (clk),
  .rst                 (rst),
  .req_ready           (request.ready),
  .res_valid           (result.valid),
  .res_ready           (result.ready),
  .res_replaced        (result.replaced),
  .res_last            (result.last),
  .res_moved_fitness   (result.moved_fitness),
  .res_population_slot (result.population_slot)
);

FILE: bench/steady_state_replacement_top_tb.sv
// -----------------------------------------------------------------------------
// steady_state_replacement_top_tb
// Self-checking bench for the steady-state replacement block. Loads and runs
// go in through the request channel and are mirrored in a predictor that
// expects every round result. Results are checked field by field, in order.
// active_count is swept through several settings, the extremes among them,
// and is only written while the block is idle.
// -----------------------------------------------------------------------------
module steady_state_replacement_top_tb;
  import ssr_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 5;
  localparam int TARGET_ITEMS  = 170;
  localparam int CALM_AFTER    = 140;
  localparam int ROUND_CYCLES  = MAX_ENTRIES + 1;
  localparam int SETTLE_CYCLES = 2 * ROUND_CYCLES;
  localparam int LIMIT_CYCLES  = 2000000;
  localparam int REPORT_MAX    = 10;

  // command code the block must ignore
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef enum int {
    FIT_ANY,
    FIT_TIES,
    FIT_EDGES
  } fit_mode_t;

  typedef struct packed {
    logic [SLOT_W-1:0] population_slot;
    logic [SLOT_W-1:0] offspring_slot;
    logic              replaced;
    logic [FIT_W-1:0]  moved_fitness;
    logic              last;
  } round_result_t;

  // Mirrors both fitness stores and queues the round results of each run.
  class replacement_predictor;
    logic [FIT_W-1:0] pop_fit[MAX_ENTRIES];
    logic [FIT_W-1:0] off_fit[MAX_ENTRIES];
    logic [ACT_W-1:0] active_count;
    round_result_t    expected_rounds[$];
    int               errors;
    int               rounds_checked;

    function new();
      active_count   = 6'd32;
      errors         = 0;
      rounds_checked = 0;
      foreach (pop_fit[i]) begin
        pop_fit[i] = '0;
        off_fit[i] = '0;
      end
    endfunction

    function int entries_in_use();
      return (active_count > MAX_ENTRIES) ? MAX_ENTRIES : int'(active_count);
    endfunction

    function void note_request(input logic [CMD_W-1:0] command,
                               input logic [SLOT_W-1:0] slot,
                               input logic [FIT_W-1:0] fitness);
      int n;
      int worst_i;
      int best_i;
      round_result_t r;
      n = entries_in_use();
      case (command)
        CMD_LOAD_POP: if (slot < n) pop_fit[slot] = fitness;
        CMD_LOAD_OFF: if (slot < n) off_fit[slot] = fitness;
        CMD_RUN: begin
          for (int rnd = 0; rnd < n; rnd++) begin
            worst_i = 0;
            best_i  = 0;
            // strict compares keep the first index on ties
            for (int j = 1; j < n; j++) begin
              if (pop_fit[j] < pop_fit[worst_i]) worst_i = j;
              if (off_fit[j] > off_fit[best_i]) best_i = j;
            end
            r.population_slot = SLOT_W'(worst_i);
            r.offspring_slot  = SLOT_W'(best_i);
            r.replaced        = off_fit[best_i] > pop_fit[worst_i];
            r.moved_fitness   = off_fit[best_i];
            r.last            = (rnd == n - 1);
            if (r.replaced) pop_fit[worst_i] = off_fit[best_i];
            off_fit[best_i] = '0;
            expected_rounds.push_back(r);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(input round_result_t got);
      round_result_t exp;
      if (expected_rounds.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("ERROR: unexpected result pop_slot=%0d off_slot=%0d rep=%0b fit=%h last=%0b",
                   got.population_slot, got.offspring_slot, got.replaced,
                   got.moved_fitness, got.last);
        return;
      end
      exp = expected_rounds.pop_front();
      rounds_checked++;
      if (got.population_slot !== exp.population_slot ||
          got.offspring_slot !== exp.offspring_slot ||
          got.replaced !== exp.replaced ||
          got.moved_fitness !== exp.moved_fitness ||
          got.last !== exp.last) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display({"ERROR: round %0d exp pop=%0d off=%0d rep=%0b fit=%h last=%0b,",
                    " got pop=%0d off=%0d rep=%0b fit=%h last=%0b"},
                   rounds_checked, exp.population_slot, exp.offspring_slot, exp.replaced,
                   exp.moved_fitness, exp.last, got.population_slot, got.offspring_slot,
                   got.replaced, got.moved_fitness, got.last);
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  ssr_req_if req_ch();
  ssr_res_if res_ch();
  ssr_cfg_if cfg_ch();

  steady_state_replacement_top u_dut (
    .clk     (clk),
    .rst     (rst),
    .request (req_ch),
    .result  (res_ch),
    .cfg     (cfg_ch)
  );

  replacement_predictor replacement;

  bit   pop_loaded[MAX_ENTRIES];
  bit   off_loaded[MAX_ENTRIES];
  bit   calm;
  int   applied_items;
  int   runs_sent;
  int   settings_written;
  int   cycles;
  int   stall_left;
  int   free_left;
  round_result_t seen;

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("steady_state_replacement_top_tb NOT OK");
      $finish;
    end
  end

  // result receiver: random stall bursts, always ready once calm
  always @(posedge clk) begin
    if (rst || calm) begin
      res_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      res_ch.ready <= 1'b0;
    end else if (free_left > 0) begin
      free_left--;
      res_ch.ready <= 1'b1;
    end else if ($urandom_range(0, 1) == 0) begin
      stall_left = $urandom_range(1, 10) - 1;
      res_ch.ready <= 1'b0;
    end else begin
      free_left = $urandom_range(1, 40) - 1;
      res_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      seen.population_slot = res_ch.population_slot;
      seen.offspring_slot  = res_ch.offspring_slot;
      seen.replaced        = res_ch.replaced;
      seen.moved_fitness   = res_ch.moved_fitness;
      seen.last            = res_ch.last;
      replacement.check_result(seen);
    end
  end

  function automatic logic [FIT_W-1:0] pick_fitness(input fit_mode_t mode);
    logic [FIT_W-1:0] edges[4];
    edges = '{16'h0000, 16'h0001, 16'hFFFE, 16'hFFFF};
    case (mode)
      FIT_TIES:  return FIT_W'($urandom_range(0, 3));
      FIT_EDGES: return edges[$urandom_range(0, 3)];
      default:   return FIT_W'($urandom);
    endcase
  endfunction

  // valid stays high after an accepted request; every pause lowers it first
  task automatic send_request(input logic [CMD_W-1:0] command,
                              input logic [SLOT_W-1:0] slot,
                              input logic [FIT_W-1:0] fitness);
    int n;
    if (!calm && $urandom_range(0, 4) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.command    <= command;
    req_ch.slot       <= slot;
    req_ch.fitness_in <= fitness;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    n = replacement.entries_in_use();
    replacement.note_request(command, slot, fitness);
    applied_items++;
    if ((command == CMD_LOAD_POP || command == CMD_LOAD_OFF) && slot < n) begin
      if (command == CMD_LOAD_POP) pop_loaded[slot] = 1'b1;
      else off_loaded[slot] = 1'b1;
    end else if (command == CMD_RUN && n > 0) begin
      runs_sent++;
    end
    if (applied_items >= CALM_AFTER) calm = 1'b1;
  endtask

  task automatic wait_results_drained();
    req_ch.valid <= 1'b0;
    while (replacement.expected_rounds.size() != 0) @(posedge clk);
  endtask

  task automatic write_active_count(input logic [ACT_W-1:0] value);
    wait_results_drained();
    // a run of zero rounds leaves nothing to wait on; let it finish
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_ch.valid        <= 1'b1;
    cfg_ch.active_count <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    replacement.active_count = value;
    settings_written++;
  endtask

  // a run may only read entries that were loaded since reset
  task automatic fill_unloaded(input fit_mode_t mode);
    int n;
    n = replacement.entries_in_use();
    for (int j = 0; j < n; j++) begin
      if (!pop_loaded[j]) send_request(CMD_LOAD_POP, SLOT_W'(j), pick_fitness(mode));
      if (!off_loaded[j]) send_request(CMD_LOAD_OFF, SLOT_W'(j), pick_fitness(mode));
    end
  endtask

  task automatic load_and_run(input fit_mode_t mode);
    int n;
    int sel;
    n = replacement.entries_in_use();
    if (n <= 8 && $urandom_range(0, 1) == 0) begin
      for (int j = 0; j < n; j++) begin
        send_request(CMD_LOAD_POP, SLOT_W'(j), pick_fitness(mode));
        send_request(CMD_LOAD_OFF, SLOT_W'(j), pick_fitness(mode));
      end
    end else begin
      repeat ($urandom_range(0, 8)) begin
        sel = $urandom_range(0, 9);
        if (sel == 0)
          send_request(CMD_UNUSED, SLOT_W'($urandom), FIT_W'($urandom));
        else if (sel == 1 && n < MAX_ENTRIES)
          send_request($urandom_range(0, 1) ? CMD_LOAD_OFF : CMD_LOAD_POP,
                       SLOT_W'($urandom_range(n, MAX_ENTRIES - 1)), FIT_W'($urandom));
        else
          send_request($urandom_range(0, 1) ? CMD_LOAD_OFF : CMD_LOAD_POP,
                       SLOT_W'($urandom_range(0, n - 1)), pick_fitness(mode));
      end
    end
    fill_unloaded(mode);
    if ($urandom_range(0, 3) == 0) wait_results_drained();
    send_request(CMD_RUN, SLOT_W'($urandom), FIT_W'($urandom));
  endtask

  initial begin
    logic [ACT_W-1:0] sweep[12];
    int phase;
    logic [ACT_W-1:0] next_count;
    sweep = '{6'd4, 6'd33, 6'd2, 6'd6, 6'd1, 6'd63, 6'd3, 6'd8, 6'd5, 6'd32, 6'd7, 6'd2};
    replacement = new();
    clk                 = 1'b0;
    rst                 = 1'b1;
    calm                = 1'b0;
    cycles              = 0;
    stall_left          = 0;
    free_left           = 0;
    applied_items       = 0;
    runs_sent           = 0;
    settings_written    = 0;
    req_ch.valid        = 1'b0;
    req_ch.command      = CMD_LOAD_POP;
    req_ch.slot         = '0;
    req_ch.fitness_in   = '0;
    res_ch.ready        = 1'b1;
    cfg_ch.valid        = 1'b0;
    cfg_ch.active_count = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // extremes: zero against full scale, then all-zero offspring on round two
    write_active_count(6'd2);
    send_request(CMD_LOAD_POP, 5'd0, 16'h0000);
    send_request(CMD_LOAD_POP, 5'd1, 16'hFFFF);
    send_request(CMD_LOAD_OFF, 5'd0, 16'hFFFF);
    send_request(CMD_LOAD_OFF, 5'd1, 16'h0000);
    send_request(CMD_RUN, 5'd0, 16'h0000);
    // slots beyond the count and the unused command are dropped
    send_request(CMD_LOAD_POP, 5'd2, 16'h1234);
    send_request(CMD_LOAD_OFF, 5'd31, 16'hFFFF);
    send_request(CMD_UNUSED, 5'd31, 16'hFFFF);
    // equal values everywhere: first index wins, nothing replaced
    send_request(CMD_LOAD_POP, 5'd0, 16'h8000);
    send_request(CMD_LOAD_POP, 5'd1, 16'h8000);
    send_request(CMD_LOAD_OFF, 5'd0, 16'h8000);
    send_request(CMD_LOAD_OFF, 5'd1, 16'h8000);
    send_request(CMD_RUN, 5'd31, 16'hFFFF);
    // zero count: loads ignored, run gives nothing
    write_active_count(6'd0);
    send_request(CMD_LOAD_POP, 5'd0, 16'h0001);
    send_request(CMD_RUN, 5'd0, 16'h0000);
    write_active_count(6'd1);
    send_request(CMD_LOAD_POP, 5'd0, 16'h0001);
    send_request(CMD_LOAD_OFF, 5'd0, 16'h0001);
    send_request(CMD_RUN, 5'd0, 16'h0000);
    send_request(CMD_LOAD_OFF, 5'd0, 16'h0002);
    send_request(CMD_RUN, 5'd0, 16'h0000);
    write_active_count(6'd3);
    fill_unloaded(FIT_EDGES);
    send_request(CMD_RUN, 5'd0, 16'h0000);

    phase = 0;
    while (applied_items < TARGET_ITEMS) begin
      next_count = (phase < 12) ? sweep[phase] : ACT_W'($urandom_range(1, 8));
      phase++;
      write_active_count(next_count);
      repeat ($urandom_range(1, 3))
        load_and_run(fit_mode_t'($urandom_range(FIT_ANY, FIT_EDGES)));
    end

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d accepted requests with %0d runs over %0d active_count settings",
             applied_items, runs_sent, settings_written);
    $display("checked %0d round results, %0d errors", replacement.rounds_checked,
             replacement.errors);
    if (replacement.errors == 0) begin
      $display("steady_state_replacement_top_tb OK");
    end else begin
      $display("steady_state_replacement_top_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/ssr_pkg.sv
hdl/ssr_channels.sv
hdl/ssr_cell.sv
hdl/ssr_ctrl.sv
hdl/steady_state_replacement_top.sv
hdl/ssr_checker.sv
bench/steady_state_replacement_top_tb.sv
